// ===== sv/vpf_pkg.sv =====
// ----------------------------------------------------------------------------
// vpf_pkg
// shared constants and types of the voxel point fusion table
// ----------------------------------------------------------------------------
package vpf_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int POS_W   = 18;
  localparam int COL_W   = 8;
  localparam int CONF_W  = 8;
  localparam int DEPTH_W = 17;
  localparam int VSIZE_W = 10;
  localparam int HITS_W  = 16;
  localparam int KQ_W    = 11;
  localparam int KEY_W   = 3 * KQ_W;
  localparam int STAT_W  = 2;
  localparam int OIDX_W  = 12;
  localparam int OTOT_W  = 13;
  localparam int MERGE_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONF_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOXEL_SIZE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_CAP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STABLE_HITS = 3'd5;

  localparam logic [STAT_W-1:0] ST_REJECTED = 2'd0;
  localparam logic [STAT_W-1:0] ST_MERGED   = 2'd1;
  localparam logic [STAT_W-1:0] ST_CREATED  = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [2:0][POS_W-1:0] pos;
    logic [2:0][COL_W-1:0] col;
    logic [CONF_W-1:0]     opacity;
    logic [HITS_W-1:0]     hits;
    logic                  stable;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== sv/vpf_if.sv =====
// ----------------------------------------------------------------------------
// vpf point and result channels
// valid/ready channels for input points and fusion results
// ----------------------------------------------------------------------------
interface vpf_point_if;
  import vpf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  logic [COL_W-1:0]         red;
  logic [COL_W-1:0]         green;
  logic [COL_W-1:0]         blue;
  logic [CONF_W-1:0]        confidence;
  modport source (output valid, pos_x, pos_y, pos_z, red, green, blue, confidence,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, red, green, blue, confidence,
                output ready);
endinterface

interface vpf_result_if;
  import vpf_pkg::*;
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [OIDX_W-1:0]  entry_index;
  logic [OTOT_W-1:0]  entry_total;
  logic [OTOT_W-1:0]  stable_total;
  logic [MERGE_W-1:0] merged_total;
  modport source (output valid, status, entry_index, entry_total, stable_total,
                  merged_total, input ready);
  modport sink (input valid, status, entry_index, entry_total, stable_total,
                merged_total, output ready);
endinterface

// ===== sv/vpf_ram.sv =====
// ----------------------------------------------------------------------------
// vpf_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module vpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/voxel_point_fusion_table_core.sv =====
// ----------------------------------------------------------------------------
// voxel_point_fusion_table_core
// fuses 3d points into a bounded table of voxels with weighted blending
// ----------------------------------------------------------------------------
// One point is taken at a time; ready stays low until its result is loaded
// into the output register. An accepted point runs three floor divisions
// for its voxel key on one shared radix-2 divider, then a linear key search
// through the key ram at one entry per cycle that stops at the first match,
// and on a hit a data ram read through S_DREAD and S_DLOAD and six more
// blend divisions on the same divider. The rams need no clearing after
// reset: only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module voxel_point_fusion_table_core (
  input  logic                           clk,
  input  logic                           rst,
  vpf_point_if.sink                      point_in,
  vpf_result_if.source                   result_out,
  input  logic                           cfg_we,
  input  logic [vpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vpf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import vpf_pkg::*;

  localparam int NUM_W  = 28;
  localparam int MAG_W  = NUM_W - 1;
  localparam int STEP_W = $clog2(MAG_W);

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_DIV, S_DIVEND, S_SEARCH, S_DREAD, S_DLOAD, S_WRITE, S_FIN
  } state_t;

  state_t state;

  logic [DEPTH_W-1:0] depth_min, depth_max;
  logic [CONF_W-1:0]  confidence_min, weight_cap;
  logic [VSIZE_W-1:0] voxel_size;
  logic [HITS_W-1:0]  stable_hits;

  logic [2:0][POS_W-1:0] pt_pos;
  logic [2:0][COL_W-1:0] pt_col;
  logic [CONF_W-1:0]     pt_conf;

  logic [CNT_W-1:0]   entry_count, stable_count, scan;
  logic [MERGE_W-1:0] merge_count;

  logic [2:0][KQ_W-1:0] key_q;
  logic                 blend_phase;
  logic [2:0]           slot;
  logic                 found, chk_vld;
  logic [IDX_W-1:0]     chk_idx, hit_idx;
  entry_t               ent;
  logic [STAT_W-1:0]    status_r;

  logic [MAG_W-1:0]   div_num;
  logic [VSIZE_W-1:0] div_den, div_rem;
  logic               div_neg;
  logic [STEP_W-1:0]  div_step;

  logic               res_valid;
  logic [STAT_W-1:0]  res_status;
  logic [OIDX_W-1:0]  res_index;
  logic [OTOT_W-1:0]  res_entries, res_stables;
  logic [MERGE_W-1:0] res_merged;

  logic               key_we, data_we;
  logic [KEY_W-1:0]   key_rdata;
  entry_t             data_rdata, data_wdata;
  logic [IDX_W-1:0]   data_waddr;

  // point window check
  logic signed [POS_W:0] z_ext;
  logic                  reject;
  assign z_ext  = {point_in.pos_z[POS_W-1], point_in.pos_z};
  assign reject = (z_ext < $signed({2'b00, depth_min})) ||
                  (z_ext > $signed({2'b00, depth_max})) ||
                  (point_in.confidence < confidence_min);

  // numerator of the next division
  logic [CONF_W-1:0]        w;
  logic signed [NUM_W-1:0]  old_ext, new_ext, w_ext, num;
  logic [VSIZE_W-1:0]       den;
  assign w = (pt_conf < weight_cap) ? pt_conf : weight_cap;

  always_comb begin
    old_ext = '0;
    new_ext = '0;
    w_ext   = NUM_W'({1'b0, w});
    num     = '0;
    den     = (voxel_size == '0) ? VSIZE_W'(1) : voxel_size;
    if (!blend_phase) begin
      num = NUM_W'($signed(pt_pos[slot[1:0]]));
    end else begin
      if (slot < 3'd3) begin
        old_ext = NUM_W'($signed(ent.pos[slot[1:0]]));
        new_ext = NUM_W'($signed(pt_pos[slot[1:0]]));
      end else begin
        old_ext = NUM_W'({1'b0, ent.col[2'(slot - 3'd3)]});
        new_ext = NUM_W'({1'b0, pt_col[2'(slot - 3'd3)]});
      end
      num = (old_ext <<< 8) - old_ext + new_ext * w_ext;
      den = VSIZE_W'(9'd255 + 9'(w));
    end
  end

  // one restoring divide step
  logic [VSIZE_W:0]   trial;
  logic               q_bit;
  logic [VSIZE_W-1:0] rem_next;
  assign trial    = {div_rem, div_num[MAG_W-1]};
  assign q_bit    = trial >= {1'b0, div_den};
  assign rem_next = q_bit ? VSIZE_W'(trial - {1'b0, div_den}) : VSIZE_W'(trial);

  // floor quotient
  logic signed [NUM_W-1:0] q_floor;
  always_comb begin
    q_floor = $signed({1'b0, div_num});
    if (div_neg) begin
      q_floor = -q_floor - NUM_W'(div_rem != '0);
    end
  end

  // merged entry update
  entry_t           ent_upd;
  logic [HITS_W-1:0] hits_next;
  logic              becomes_stable;
  assign hits_next      = (ent.hits != '1) ? ent.hits + 1'b1 : ent.hits;
  assign becomes_stable = (hits_next >= stable_hits) && !ent.stable;
  always_comb begin
    ent_upd        = ent;
    ent_upd.hits   = hits_next;
    ent_upd.stable = ent.stable | becomes_stable;
  end

  always_comb begin
    key_we     = 1'b0;
    data_we    = 1'b0;
    data_waddr = hit_idx;
    data_wdata = ent_upd;
    if (state == S_WRITE) begin
      if (found) begin
        data_we = 1'b1;
      end else if (entry_count < CNT_W'(TABLE_ENTRIES)) begin
        key_we             = 1'b1;
        data_we            = 1'b1;
        data_waddr         = entry_count[IDX_W-1:0];
        data_wdata.pos     = pt_pos;
        data_wdata.col     = pt_col;
        data_wdata.opacity = pt_conf;
        data_wdata.hits    = HITS_W'(1);
        data_wdata.stable  = 1'b0;
      end
    end
  end

  vpf_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (entry_count[IDX_W-1:0]),
    .wdata (key_q),
    .raddr (scan[IDX_W-1:0]),
    .rdata (key_rdata)
  );

  vpf_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (data_wdata),
    .raddr (hit_idx),
    .rdata (data_rdata)
  );

  assign point_in.ready          = (state == S_IDLE);
  assign result_out.valid        = res_valid;
  assign result_out.status       = res_status;
  assign result_out.entry_index  = res_index;
  assign result_out.entry_total  = res_entries;
  assign result_out.stable_total = res_stables;
  assign result_out.merged_total = res_merged;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      depth_min      <= DEPTH_W'(500);
      depth_max      <= DEPTH_W'(80000);
      confidence_min <= CONF_W'(13);
      voxel_size     <= VSIZE_W'(100);
      weight_cap     <= CONF_W'(128);
      stable_hits    <= HITS_W'(3);
      entry_count    <= '0;
      stable_count   <= '0;
      merge_count    <= '0;
      res_valid      <= 1'b0;
      found          <= 1'b0;
      chk_vld        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEPTH_MIN:   depth_min      <= cfg_wdata;
          REG_DEPTH_MAX:   depth_max      <= cfg_wdata;
          REG_CONF_MIN:    confidence_min <= cfg_wdata[CONF_W-1:0];
          REG_VOXEL_SIZE:  voxel_size     <= cfg_wdata[VSIZE_W-1:0];
          REG_WEIGHT_CAP:  weight_cap     <= cfg_wdata[CONF_W-1:0];
          REG_STABLE_HITS: stable_hits    <= cfg_wdata[HITS_W-1:0];
          default: ;
        endcase
      end
      if (res_valid && result_out.ready && state != S_FIN) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (point_in.valid) begin
            pt_pos      <= {point_in.pos_z, point_in.pos_y, point_in.pos_x};
            pt_col      <= {point_in.blue, point_in.green, point_in.red};
            pt_conf     <= point_in.confidence;
            blend_phase <= 1'b0;
            slot        <= '0;
            found       <= 1'b0;
            if (reject) begin
              status_r <= ST_REJECTED;
              state    <= S_FIN;
            end else begin
              state <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          div_neg  <= num[NUM_W-1];
          div_num  <= num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
          div_den  <= den;
          div_rem  <= '0;
          div_step <= '0;
          state    <= S_DIV;
        end
        S_DIV: begin
          div_num  <= {div_num[MAG_W-2:0], q_bit};
          div_rem  <= rem_next;
          div_step <= div_step + 1'b1;
          if (div_step == STEP_W'(MAG_W - 1)) begin
            state <= S_DIVEND;
          end
        end
        S_DIVEND: begin
          slot <= slot + 1'b1;
          if (!blend_phase) begin
            key_q[2'(3'd2 - slot)] <= q_floor[KQ_W-1:0];
            if (slot == 3'd2) begin
              scan    <= '0;
              chk_vld <= 1'b0;
              state   <= S_SEARCH;
            end else begin
              state <= S_SETUP;
            end
          end else begin
            if (slot < 3'd3) begin
              ent.pos[slot[1:0]] <= q_floor[POS_W-1:0];
            end else begin
              ent.col[2'(slot - 3'd3)] <= q_floor[COL_W-1:0];
            end
            state <= (slot == 3'd5) ? S_WRITE : S_SETUP;
          end
        end
        S_SEARCH: begin
          if (chk_vld && key_rdata == key_q) begin
            found   <= 1'b1;
            hit_idx <= chk_idx;
            state   <= S_DREAD;
          end else if (scan < entry_count) begin
            chk_vld <= 1'b1;
            chk_idx <= scan[IDX_W-1:0];
            scan    <= scan + 1'b1;
          end else if (chk_vld) begin
            chk_vld <= 1'b0;
          end else begin
            state <= S_WRITE;
          end
        end
        S_DREAD: begin
          state <= S_DLOAD;
        end
        S_DLOAD: begin
          ent         <= data_rdata;
          blend_phase <= 1'b1;
          slot        <= '0;
          state       <= S_SETUP;
        end
        S_WRITE: begin
          if (found) begin
            status_r <= ST_MERGED;
            if (becomes_stable) begin
              stable_count <= stable_count + 1'b1;
            end
            if (merge_count != '1) begin
              merge_count <= merge_count + 1'b1;
            end
          end else if (entry_count < CNT_W'(TABLE_ENTRIES)) begin
            status_r    <= ST_CREATED;
            hit_idx     <= entry_count[IDX_W-1:0];
            entry_count <= entry_count + 1'b1;
          end else begin
            status_r <= ST_FULL;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!res_valid || result_out.ready) begin
            res_valid   <= 1'b1;
            res_status  <= status_r;
            res_index   <= (status_r == ST_MERGED || status_r == ST_CREATED) ?
                           OIDX_W'(hit_idx) : '0;
            res_entries <= OTOT_W'(entry_count);
            res_stables <= OTOT_W'(stable_count);
            res_merged  <= merge_count;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count beyond table size");

  a_stable_bound: assert property (@(posedge clk) disable iff (rst)
    stable_count <= entry_count)
    else $error("more stable entries than entries");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (point_in.valid && point_in.ready) |=> !point_in.ready)
    else $error("item accepted while another is in work");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_rem < div_den))
    else $error("divider remainder out of range");

endmodule
